/* rtl/suks_pkg.sv */
// ----------------------------------------------------------------------------
// suks_pkg
// shared types and codes for the sorted unique key set
// ----------------------------------------------------------------------------
package suks_pkg;

   localparam int KEY_W    = 32;
   localparam int STATUS_W = 3;
   localparam int OUT_W    = 5;

   // request operations
   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_DELETE = 1'b1;

   // response status codes
   localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd0;
   localparam logic [STATUS_W-1:0] ST_DUPLICATE = 3'd1;
   localparam logic [STATUS_W-1:0] ST_DELETED   = 3'd2;
   localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd3;
   localparam logic [STATUS_W-1:0] ST_FULL      = 3'd4;

   typedef struct packed {
      logic                    req_type;
      logic signed [KEY_W-1:0] key;
   } suks_req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [OUT_W-1:0]    position;
      logic [OUT_W-1:0]    entry_count;
   } suks_rsp_type;

   // control broadcast to every cell
   typedef struct packed {
      logic compare;
      logic insert;
      logic delete;
   } suks_cell_ctl_type;

   // per-cell status back to the top level
   typedef struct packed {
      logic lt;
      logic boundary;
      logic hit;
   } suks_cell_stat_type;

endpackage

/* rtl/suks_cell.sv */
// ----------------------------------------------------------------------------
// suks_cell
// one slot of the ordered key row: compare, then shift with neighbors
// ----------------------------------------------------------------------------
module suks_cell
   import suks_pkg::*;
#(
   parameter int INDEX = 0,
   parameter int CNT_W = 5
) (
   input  logic                    clock,
   input  suks_cell_ctl_type       ctl,
   input  logic signed [KEY_W-1:0] req_key,
   input  logic [CNT_W-1:0]        count,
   input  logic signed [KEY_W-1:0] left_key,
   input  logic signed [KEY_W-1:0] right_key,
   input  logic                    lt_prev,
   output logic signed [KEY_W-1:0] key_out,
   output suks_cell_stat_type      stat
);

   logic signed [KEY_W-1:0] key_ff;
   logic                    lt_ff;
   logic                    eq_ff;
   logic                    occupied;
   logic                    boundary;

   assign occupied = count > CNT_W'(INDEX);
   // first slot that is empty or whose key is not below the request key
   assign boundary = lt_prev && !lt_ff;

   always_ff @(posedge clock) begin
      if (ctl.compare) begin
         lt_ff <= occupied && (key_ff < req_key);
         eq_ff <= occupied && (key_ff == req_key);
      end
      if (ctl.insert && !lt_ff) begin
         key_ff <= boundary ? req_key : left_key;
      end else if (ctl.delete && !lt_ff) begin
         key_ff <= right_key;
      end
   end

   assign key_out       = key_ff;
   assign stat.lt       = lt_ff;
   assign stat.boundary = boundary;
   assign stat.hit      = boundary && eq_ff;

endmodule

/* rtl/suks_encoder.sv */
// ----------------------------------------------------------------------------
// suks_encoder
// turns the one-hot boundary marker of the cell row into an index
// ----------------------------------------------------------------------------
module suks_encoder
   import suks_pkg::*;
#(
   parameter int CAPACITY = 16,
   parameter int POS_W    = 5
) (
   input  logic [CAPACITY-1:0] boundary,
   input  logic                all_lt,
   output logic [POS_W-1:0]    position
);

   logic [POS_W-1:0] enc;

   always_comb begin
      enc = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         if (boundary[i]) begin
            enc = enc | POS_W'(i);
         end
      end
   end

   // every slot holds a smaller key: place after the last slot
   assign position = all_lt ? POS_W'(CAPACITY) : enc;

endmodule

/* rtl/sorted_unique_key_set_unit.sv */
// ----------------------------------------------------------------------------
// sorted_unique_key_set_unit
// ordered set of distinct signed keys with insert and delete requests
// ----------------------------------------------------------------------------
//
//   channel   ports                          payload
//   -------   ----------------------------   ---------------------------------
//   request   req_valid req_stall req_data   req_type (0 insert, 1 delete), key
//   response  rsp_valid rsp_stall rsp_data   status, position, entry_count
//
// requests are handled one at a time: accept, parallel compare in all cells,
// then position encode plus shift of the cell row in the update state; the
// update state waits while a previous response is still stalled; a new
// request is taken while a finished response waits in its register
// synchronous active-high reset clears the fsm, held count and response valid;
// the key cells have no reset, slots at or above the count are never used
// ----------------------------------------------------------------------------
module sorted_unique_key_set_unit
   import suks_pkg::*;
#(
   parameter int CAPACITY = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  suks_req_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output suks_rsp_type rsp_data
);

   localparam int CNT_W = $clog2(CAPACITY + 1);

   // fsm codes
   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_CMP  = 2'd1;
   localparam logic [1:0] ST_UPD  = 2'd2;

   logic [1:0]         state_ff, state_in;
   suks_req_type       req_ff;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               rsp_valid_ff, rsp_valid_in;
   suks_rsp_type       rsp_ff;

   suks_cell_ctl_type  ctl;
   suks_cell_stat_type stat [CAPACITY];
   logic signed [KEY_W-1:0] cell_key [CAPACITY];
   logic [CAPACITY-1:0] lt_vec;
   logic [CAPACITY-1:0] boundary_vec;
   logic [CAPACITY-1:0] hit_vec;

   logic               found;
   logic               room;
   logic               do_insert;
   logic               do_delete;
   logic               rsp_load;
   logic [CNT_W-1:0]   position;
   logic [STATUS_W-1:0] status;

   // request accepted only when the fsm is idle
   assign req_stall = (state_ff != ST_IDLE);

   // response register frees up this cycle or is already empty
   assign rsp_load = (state_ff == ST_UPD) && (!rsp_valid_ff || !rsp_stall);

   assign found = |hit_vec;
   assign room  = count_ff < CNT_W'(CAPACITY);

   assign do_insert = rsp_load && (req_ff.req_type == OP_INSERT) && !found && room;
   assign do_delete = rsp_load && (req_ff.req_type == OP_DELETE) && found;

   assign ctl.compare = (state_ff == ST_CMP);
   assign ctl.insert  = do_insert;
   assign ctl.delete  = do_delete;

   // cell row: each slot sees its left and right neighbor keys
   for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
      logic signed [KEY_W-1:0] left_key;
      logic signed [KEY_W-1:0] right_key;
      logic                    lt_prev;

      if (g == 0) begin : g_first
         assign left_key = cell_key[g];
         assign lt_prev  = 1'b1;
      end else begin : g_mid
         assign left_key = cell_key[g-1];
         assign lt_prev  = stat[g-1].lt;
      end
      if (g == CAPACITY - 1) begin : g_last
         assign right_key = cell_key[g];
      end else begin : g_inner
         assign right_key = cell_key[g+1];
      end

      suks_cell #(
         .INDEX (g),
         .CNT_W (CNT_W)
      ) u_cell (
         .clock     (clock),
         .ctl       (ctl),
         .req_key   (req_ff.key),
         .count     (count_ff),
         .left_key  (left_key),
         .right_key (right_key),
         .lt_prev   (lt_prev),
         .key_out   (cell_key[g]),
         .stat      (stat[g])
      );

      assign lt_vec[g]       = stat[g].lt;
      assign boundary_vec[g] = stat[g].boundary;
      assign hit_vec[g]      = stat[g].hit;
   end

   suks_encoder #(
      .CAPACITY (CAPACITY),
      .POS_W    (CNT_W)
   ) u_encoder (
      .boundary (boundary_vec),
      .all_lt   (lt_vec[CAPACITY-1]),
      .position (position)
   );

   // status decode
   always_comb begin
      if (req_ff.req_type == OP_INSERT) begin
         if (found) begin
            status = ST_DUPLICATE;
         end else if (!room) begin
            status = ST_FULL;
         end else begin
            status = ST_INSERTED;
         end
      end else begin
         status = found ? ST_DELETED : ST_NOT_FOUND;
      end
   end

   always_comb begin
      count_in = count_ff;
      if (do_insert) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_delete) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_CMP;
            end
         end
         ST_CMP: begin
            state_in = ST_UPD;
         end
         ST_UPD: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && req_valid) begin
         req_ff <= req_data;
      end
      if (rsp_load) begin
         rsp_ff.status      <= status;
         rsp_ff.position    <= OUT_W'(position);
         rsp_ff.entry_count <= OUT_W'(count_in);
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // held count stays within the row
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("held count exceeds capacity");

   // the compare result forms a thermometer, so at most one boundary
   a_one_boundary: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_UPD) |-> $onehot0(boundary_vec))
      else $error("more than one boundary cell");

   // a delete response removes exactly one key
   a_delete_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_load && status == ST_DELETED) |=> (count_ff == $past(count_ff) - CNT_W'(1)))
      else $error("delete did not decrement count");

endmodule

/* bench/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the sorted unique key set: drives insert and delete
// requests with random gaps and response stalls, predicts every response from
// a private copy of the ordered set and checks each field in order
// ----------------------------------------------------------------------------
module tb;
   import suks_pkg::*;

   localparam int CAPACITY     = 16;
   localparam int RANDOM_ITEMS = 1100;
   localparam int QUIET_ITEMS  = 150;   // tail of the run with no idling
   localparam int STALL_LIMIT  = 4000;  // cycles with no accepted request or response

   // ordered-set predictor plus the queue of responses still owed by the block
   class key_set_tracker;
      logic signed [KEY_W-1:0] held_keys[CAPACITY];
      int                      held;
      suks_rsp_type            owed_rsp[$];
      int                      fail_count;
      int                      requests;
      int                      responses;
      int                      status_seen[5];

      function new();
         held       = 0;
         fail_count = 0;
         requests   = 0;
         responses  = 0;
         foreach (status_seen[i]) status_seen[i] = 0;
      endfunction

      function int pending();
         return owed_rsp.size();
      endfunction

      // apply one accepted request to the set and queue the response it owes
      function void note_request(suks_req_type r);
         int           pos;
         bit           found;
         suks_rsp_type e;
         pos = 0;
         while (pos < held && held_keys[pos] < r.key) pos++;
         found = (pos < held) && (held_keys[pos] == r.key);
         if (r.req_type == OP_INSERT) begin
            if (found) begin
               e.status = ST_DUPLICATE;
            end else if (held >= CAPACITY) begin
               e.status = ST_FULL;
            end else begin
               for (int i = held; i > pos; i--) held_keys[i] = held_keys[i-1];
               held_keys[pos] = r.key;
               held++;
               e.status = ST_INSERTED;
            end
         end else begin
            if (found) begin
               for (int i = pos; i + 1 < held; i++) held_keys[i] = held_keys[i+1];
               held--;
               e.status = ST_DELETED;
            end else begin
               e.status = ST_NOT_FOUND;
            end
         end
         e.position    = OUT_W'(pos);
         e.entry_count = OUT_W'(held);
         owed_rsp.push_back(e);
         status_seen[e.status]++;
         requests++;
      endfunction

      function void check_response(suks_rsp_type got);
         suks_rsp_type e;
         responses++;
         if (owed_rsp.size() == 0) begin
            $error("response with nothing owed: status %0d position %0d count %0d",
                   got.status, got.position, got.entry_count);
            fail_count++;
            return;
         end
         e = owed_rsp.pop_front();
         if (got.status !== e.status) begin
            $error("status mismatch: expected %0d, actual %0d", e.status, got.status);
            fail_count++;
         end
         if (got.position !== e.position) begin
            $error("position mismatch: expected %0d, actual %0d", e.position, got.position);
            fail_count++;
         end
         if (got.entry_count !== e.entry_count) begin
            $error("entry_count mismatch: expected %0d, actual %0d",
                   e.entry_count, got.entry_count);
            fail_count++;
         end
      endfunction
   endclass

   logic         clock;
   logic         reset     = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   suks_req_type req_data  = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   suks_rsp_type rsp_data;

   key_set_tracker tracker = new();
   bit             quiet   = 1'b0;   // no idling on either side
   int             idle_cycles = 0;

   sorted_unique_key_set_unit #(
      .CAPACITY (CAPACITY)
   ) DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // 20 ns clock
   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   // response monitor: everything the block hands over is checked in order
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         tracker.check_response(rsp_data);
      end
   end

   // watchdog: counts cycles where neither channel moves a request or response
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles + 1 >= STALL_LIMIT) begin
         $display("watchdog expired after %0d quiet cycles", STALL_LIMIT);
         $display("TEST FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // response side back-pressure: random stall bursts, with calm stretches
   // in between, and none once the run goes quiet
   initial begin
      int burst;
      forever begin
         @(negedge clock);
         if (quiet || $urandom_range(0, 7) != 0) begin
            rsp_stall <= 1'b0;
            // sometimes hold off stalls for a long stretch
            if (!quiet && $urandom_range(0, 15) == 0) repeat ($urandom_range(20, 80)) @(negedge clock);
         end else begin
            burst = $urandom_range(1, 18);
            rsp_stall <= 1'b1;
            repeat (burst - 1) @(negedge clock);
         end
      end
   end

   // present one request and hold it until the block takes it; valid stays high
   // into the next request unless a gap is inserted here first
   task automatic issue(input logic op, input logic signed [KEY_W-1:0] k);
      suks_req_type r;
      int           gap;
      if (!quiet && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 18);
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      r.req_type = op;
      r.key      = k;
      @(negedge clock);
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (req_stall);
      tracker.note_request(r);
   endtask

   initial begin
      int                      insert_pct;
      int                      episode_len;
      int                      sent;
      logic                    op;
      logic signed [KEY_W-1:0] k;

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: extremes of the key, both operations, duplicates,
      // deletes that miss, a delete on the empty set
      issue(OP_DELETE, 32'sd0);                      // delete on empty set
      issue(OP_INSERT, 32'sh7fff_ffff);              // largest key
      issue(OP_INSERT, 32'sh8000_0000);              // smallest key
      issue(OP_INSERT, 32'sd0);
      issue(OP_INSERT, -32'sd1);
      issue(OP_INSERT, 32'sd1);
      issue(OP_INSERT, 32'sd0);                      // duplicate in the middle
      issue(OP_INSERT, 32'sh8000_0000);              // duplicate at the bottom
      issue(OP_INSERT, 32'sh7fff_ffff);              // duplicate at the top
      issue(OP_DELETE, 32'sd7);                      // absent key
      issue(OP_DELETE, 32'sh8000_0001);              // absent, just above minimum
      issue(OP_DELETE, 32'sh8000_0000);
      issue(OP_DELETE, 32'sh7fff_ffff);
      issue(OP_DELETE, 32'sd0);
      issue(OP_INSERT, 32'sh5555_5555);
      issue(OP_INSERT, 32'sh2aaa_aaaa);
      issue(OP_INSERT, -32'sh5555_5556);             // 0xaaaaaaaa
      issue(OP_DELETE, -32'sd1);
      issue(OP_DELETE, 32'sd1);
      issue(OP_DELETE, 32'sh5555_5555);
      issue(OP_DELETE, 32'sh2aaa_aaaa);
      issue(OP_DELETE, -32'sh5555_5556);             // back to empty
      issue(OP_DELETE, 32'sh7fff_ffff);              // miss on empty set

      // random: episodes that lean toward filling, churning or draining the set,
      // so full refusals and empty misses both occur many times
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         case ($urandom_range(0, 2))
            0:       insert_pct = 85;
            1:       insert_pct = 50;
            default: insert_pct = 15;
         endcase
         episode_len = $urandom_range(10, 60);
         for (int n = 0; n < episode_len && sent < RANDOM_ITEMS; n++) begin
            quiet = (sent >= RANDOM_ITEMS - QUIET_ITEMS);
            op = ($urandom_range(1, 100) <= insert_pct) ? OP_INSERT : OP_DELETE;
            case ($urandom_range(0, 9))
               0, 1, 2, 3: begin
                  // a key already held: hits for delete, duplicates for insert
                  if (tracker.held > 0)
                     k = tracker.held_keys[$urandom_range(0, tracker.held - 1)];
                  else
                     k = $signed($urandom_range(0, 40)) - 20;
               end
               4: begin
                  // neighbor of a held key
                  if (tracker.held > 0)
                     k = tracker.held_keys[$urandom_range(0, tracker.held - 1)]
                         + ($urandom_range(0, 1) ? 32'sd1 : -32'sd1);
                  else
                     k = 32'sd0;
               end
               5: begin
                  case ($urandom_range(0, 5))
                     0:       k = 32'sh8000_0000;
                     1:       k = 32'sh8000_0001;
                     2:       k = 32'sh7fff_ffff;
                     3:       k = 32'sh7fff_fffe;
                     4:       k = -32'sd1;
                     default: k = 32'sd0;
                  endcase
               end
               6, 7:    k = $signed($urandom_range(0, 40)) - 20;
               default: k = $signed($urandom());
            endcase
            issue(op, k);
            sent++;
         end
      end

      @(negedge clock);
      req_valid <= 1'b0;

      // drain: watchdog bounds this wait
      while (tracker.pending() > 0) @(posedge clock);
      repeat (12) @(posedge clock);

      $display("ran %0d requests, checked %0d responses", tracker.requests, tracker.responses);
      $display("inserted %0d, duplicate %0d, deleted %0d, not found %0d, full %0d",
               tracker.status_seen[ST_INSERTED], tracker.status_seen[ST_DUPLICATE],
               tracker.status_seen[ST_DELETED], tracker.status_seen[ST_NOT_FOUND],
               tracker.status_seen[ST_FULL]);
      if (tracker.fail_count == 0 && tracker.pending() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

/* filelist.f */
rtl/suks_pkg.sv
rtl/suks_cell.sv
rtl/suks_encoder.sv
rtl/sorted_unique_key_set_unit.sv
bench/tb.sv
